// ===== hdl/csfd_pkg.sv =====
// Package for the CRC-checked sample frame decoder.
// Holds frame constants, the byte phase type and the CRC-8 byte update.
// No dependencies.
package csfd_pkg;

  localparam logic [7:0] CrcPoly    = 8'h31;
  localparam logic [7:0] CrcInit    = 8'hFF;
  localparam int unsigned FrameBytes = 9;
  localparam logic [3:0] LastPos    = 4'(FrameBytes - 1);

  // Group numbers as reported on the result (0 = no failure)
  localparam logic [1:0] GrpNone = 2'd0;
  localparam logic [1:0] GrpFlow = 2'd1;
  localparam logic [1:0] GrpTemp = 2'd2;
  localparam logic [1:0] GrpFlag = 2'd3;

  // Role of a byte inside its three-byte group
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_e;

  // CRC-8, MSB first, one byte folded in
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc_checked_sample_frame_decoder.sv =====
// Top level of the CRC-checked sample frame decoder.
// Input register, byte decode and CRC check, result register; uses csfd_pkg.
//
// Channel | Dir | tdata (low bit up)                            | tuser (low bit up)
// s_axis  | in  | rx_byte[7:0]                                  | frame_start[0]
// m_axis  | out | flow_raw[15:0] temp_raw[31:16] flags[47:32]   | frame_ok[0] bad_group[2:1]
//
// One byte per cycle sustained unless a held result stalls byte 8; the result register
// loads from byte 8 in the input register through the one-byte CRC update.
// Reset clears frame position, CRC and holds as at the start of a frame.
// A held result stalls the input register only when it has a new result to load;
// other bytes keep flowing while the result waits.
module crc_checked_sample_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte[7:0]
  input  logic        s_axis_tuser_i,   // frame_start[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // flow_raw[15:0], temp_raw[31:16], status_flags[47:32]
  output logic [2:0]  m_axis_tuser_o    // frame_ok[0], bad_group[2:1]
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Frame state
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] flow_q, flow_d;
  logic [15:0] temp_q, temp_d;
  logic [7:0]  flag_lo_q, flag_lo_d;
  logic [1:0]  fail_q, fail_d;

  // Result register
  logic        out_valid_q;
  logic [47:0] out_data_q, out_data_d;
  logic [2:0]  out_user_q, out_user_d;

  // Decode signals
  logic [3:0]         pos_eff;
  csfd_pkg::phase_e   phase;
  logic [1:0]         group;
  logic [7:0]         crc_b, hi_b, flag_lo_b, crc_upd;
  logic [15:0]        flow_b, temp_b;
  logic [1:0]         fail_b;
  logic               last_byte, consume, frame_ok;

  // Effective position: a start mark or an out-of-range count restarts at byte 0
  assign pos_eff   = (in_start_q || pos_q > csfd_pkg::LastPos) ? 4'd0 : pos_q;
  assign last_byte = (pos_eff == csfd_pkg::LastPos);
  assign consume   = in_valid_q && (!last_byte || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || consume;

  // Phase and group of the current byte
  always_comb begin
    unique case (pos_eff)
      4'd0:    begin phase = csfd_pkg::PH_HIGH; group = 2'd0; end
      4'd1:    begin phase = csfd_pkg::PH_LOW;  group = 2'd0; end
      4'd2:    begin phase = csfd_pkg::PH_CRC;  group = 2'd0; end
      4'd3:    begin phase = csfd_pkg::PH_HIGH; group = 2'd1; end
      4'd4:    begin phase = csfd_pkg::PH_LOW;  group = 2'd1; end
      4'd5:    begin phase = csfd_pkg::PH_CRC;  group = 2'd1; end
      4'd6:    begin phase = csfd_pkg::PH_HIGH; group = 2'd2; end
      4'd7:    begin phase = csfd_pkg::PH_LOW;  group = 2'd2; end
      4'd8:    begin phase = csfd_pkg::PH_CRC;  group = 2'd2; end
      default: begin phase = csfd_pkg::PH_HIGH; group = 2'd0; end
    endcase
  end

  // State as seen by this byte: cleared when the byte opens a new frame
  always_comb begin
    if (in_start_q) begin
      crc_b     = csfd_pkg::CrcInit;
      hi_b      = '0;
      flow_b    = '0;
      temp_b    = '0;
      flag_lo_b = '0;
      fail_b    = csfd_pkg::GrpNone;
    end else begin
      crc_b     = crc_q;
      hi_b      = hi_q;
      flow_b    = flow_q;
      temp_b    = temp_q;
      flag_lo_b = flag_lo_q;
      fail_b    = fail_q;
    end
  end

  assign crc_upd = csfd_pkg::crc8_byte(crc_b, in_byte_q);

  // Byte decode and next state
  always_comb begin
    crc_d     = crc_b;
    hi_d      = hi_b;
    flow_d    = flow_b;
    temp_d    = temp_b;
    flag_lo_d = flag_lo_b;
    fail_d    = fail_b;
    unique case (phase)
      csfd_pkg::PH_HIGH: begin
        hi_d  = in_byte_q;
        crc_d = crc_upd;
      end
      csfd_pkg::PH_LOW: begin
        crc_d = crc_upd;
        priority if (group == 2'd0) begin
          flow_d = {hi_b, in_byte_q};
        end else if (group == 2'd1) begin
          temp_d = {hi_b, in_byte_q};
        end else begin
          flag_lo_d = in_byte_q;
        end
      end
      default: begin
        if (crc_b != in_byte_q && fail_b == csfd_pkg::GrpNone) begin
          fail_d = group + 2'd1;
        end
        crc_d = csfd_pkg::CrcInit;
      end
    endcase
    pos_d = pos_eff + 4'd1;

    // Result fields and frame restart after the last byte
    frame_ok   = (fail_d == csfd_pkg::GrpNone);
    out_data_d = frame_ok ? {hi_d, flag_lo_d, temp_d, flow_d} : '0;
    out_user_d = {fail_d, frame_ok};
    if (last_byte) begin
      pos_d     = '0;
      crc_d     = csfd_pkg::CrcInit;
      hi_d      = '0;
      flow_d    = '0;
      temp_d    = '0;
      flag_lo_d = '0;
      fail_d    = csfd_pkg::GrpNone;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= csfd_pkg::CrcInit;
      hi_q      <= '0;
      flow_q    <= '0;
      temp_q    <= '0;
      flag_lo_q <= '0;
      fail_q    <= csfd_pkg::GrpNone;
    end else if (consume) begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      hi_q      <= hi_d;
      flow_q    <= flow_d;
      temp_q    <= temp_d;
      flag_lo_q <= flag_lo_d;
      fail_q    <= fail_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && last_byte) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && last_byte) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= csfd_pkg::LastPos)
    else $error("frame position out of range");

  a_ok_no_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[0] |-> out_user_q[2:1] == csfd_pkg::GrpNone)
    else $error("good frame reports a failing group");

  a_fail_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_user_q[0] |-> out_user_q[2:1] != csfd_pkg::GrpNone
      && out_data_q == '0)
    else $error("failed frame without group or with nonzero data");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && last_byte |=> out_valid_q && pos_q == 4'd0)
    else $error("last byte did not load a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && last_byte && out_valid_q && !m_axis_tready_i |-> !consume)
    else $error("held result would be overwritten");

endmodule

// ===== bench/csfd_frame_checker.sv =====
// Checker for the CRC-checked sample frame decoder: watches both stream channels.
// Decodes every accepted reply byte on its own and compares each result beat.
// Depends on csfd_pkg for frame constants, group codes and the byte phase type.
module csfd_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,    // rx_byte[7:0]
  input  logic        s_tuser_i,    // frame_start[0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,    // flow_raw[15:0], temp_raw[31:16], status_flags[47:32]
  input  logic [2:0]  m_tuser_i,    // frame_ok[0], bad_group[2:1]
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned compared_o,
  output int unsigned good_o
);

  typedef struct packed {
    logic signed [15:0] flow;
    logic signed [15:0] temp;
    logic [15:0]        flags;
    logic               ok;
    logic [1:0]         bad_group;
  } sample_t;

  // Samples decoded from the byte stream, oldest first
  sample_t decoded_q[$];

  // Decoder state
  logic [3:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  hi_byte;
  logic [7:0]  flag_lo;
  logic [15:0] flow_word;
  logic [15:0] temp_word;
  logic [1:0]  first_bad;

  int unsigned mismatches;
  int unsigned n_compared;
  int unsigned n_good;

  // CRC-8 over one byte, MSB first
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ csfd_pkg::CrcPoly) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  task automatic clear_frame();
    frame_pos = '0;
    crc_acc   = csfd_pkg::CrcInit;
    hi_byte   = '0;
    flag_lo   = '0;
    flow_word = '0;
    temp_word = '0;
    first_bad = csfd_pkg::GrpNone;
  endtask

  // Fold one reply byte into the frame; queue a sample after the last byte
  task automatic decode_byte(input logic [7:0] data, input logic start);
    logic [3:0] p;
    logic [1:0] grp;
    sample_t    s;
    if (start) begin
      clear_frame();
    end
    p = (frame_pos > csfd_pkg::LastPos) ? 4'd0 : frame_pos;
    grp = 2'(p / 4'd3) + 2'd1;
    unique case (csfd_pkg::phase_e'(2'(p % 4'd3)))
      csfd_pkg::PH_HIGH: begin
        hi_byte = data;
        crc_acc = crc_fold(crc_acc, data);
      end
      csfd_pkg::PH_LOW: begin
        crc_acc = crc_fold(crc_acc, data);
        if (grp == csfd_pkg::GrpFlow) begin
          flow_word = {hi_byte, data};
        end else if (grp == csfd_pkg::GrpTemp) begin
          temp_word = {hi_byte, data};
        end else begin
          flag_lo = data;
        end
      end
      default: begin
        if (crc_acc != data && first_bad == csfd_pkg::GrpNone) begin
          first_bad = grp;
        end
        crc_acc = csfd_pkg::CrcInit;
      end
    endcase
    if (p != csfd_pkg::LastPos) begin
      frame_pos = p + 4'd1;
    end else begin
      s.ok        = (first_bad == csfd_pkg::GrpNone);
      s.flow      = s.ok ? flow_word : '0;
      s.temp      = s.ok ? temp_word : '0;
      s.flags     = s.ok ? {hi_byte, flag_lo} : '0;
      s.bad_group = first_bad;
      decoded_q.push_back(s);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t: sample %0d, %s: expected %h, got %h", $time, n_compared, what, want, got);
    mismatches++;
  endtask

  // Compare one result beat against the oldest decoded sample
  task automatic check_sample(input logic [47:0] data, input logic [2:0] user);
    sample_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("result beat with no frame completed", 16'h0, data[15:0]);
    end else begin
      want = decoded_q.pop_front();
      if (data[15:0] !== want.flow) report_mismatch("flow_raw", want.flow, data[15:0]);
      if (data[31:16] !== want.temp) report_mismatch("temp_raw", want.temp, data[31:16]);
      if (data[47:32] !== want.flags) report_mismatch("status_flags", want.flags, data[47:32]);
      if (user[0] !== want.ok) report_mismatch("frame_ok", 16'(want.ok), 16'(user[0]));
      if (user[2:1] !== want.bad_group) begin
        report_mismatch("bad_group", 16'(want.bad_group), 16'(user[2:1]));
      end
      if (want.ok) n_good++;
      n_compared++;
    end
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      decoded_q.delete();
      mismatches = 0;
      n_compared = 0;
      n_good = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      compared_o <= 0;
      good_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        decode_byte(s_tdata_i, s_tuser_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_sample(m_tdata_i, m_tuser_i);
      end
      fail_count_o <= mismatches;
      pending_o <= decoded_q.size();
      compared_o <= n_compared;
      good_o <= n_good;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the CRC-checked sample frame decoder.
// Drives reply bytes and result backpressure; csfd_frame_checker does the checking.
// Depends on csfd_pkg, crc_checked_sample_frame_decoder and csfd_frame_checker.
module tb;

  localparam int unsigned ByteBudget = 550;
  localparam int unsigned MaxGap     = 18;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // rx_byte[7:0]
  logic        s_tuser;    // frame_start[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // flow_raw[15:0], temp_raw[31:16], status_flags[47:32]
  logic [2:0]  m_tuser;    // frame_ok[0], bad_group[2:1]

  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;
  int unsigned good;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  int unsigned rx_stall;
  int unsigned kind;
  int unsigned n_bytes;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  crc_checked_sample_frame_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  csfd_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared),
    .good_o       (good)
  );

  // Send one byte beat after a random gap
  task automatic push_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
  endtask

  // Full 9-byte reply; a set bit in spoil corrupts that group's CRC byte
  task automatic push_frame(input logic [15:0] flow, input logic [15:0] temp,
                            input logic [15:0] flags, input logic [2:0] spoil,
                            input logic mark);
    logic [15:0] words [3];
    logic [7:0]  crc;
    words = '{flow, temp, flags};
    for (int g = 0; g < 3; g++) begin
      crc = csfd_pkg::crc8_byte(csfd_pkg::crc8_byte(csfd_pkg::CrcInit, words[g][15:8]),
                                words[g][7:0]);
      if (spoil[g]) crc ^= 8'($urandom_range(1, 255));
      push_byte(words[g][15:8], mark && (g == 0));
      push_byte(words[g][7:0], 1'b0);
      push_byte(crc, 1'b0);
    end
  endtask

  // Hold off the sender until every completed frame has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random data word, leaning on the extremes now and then
  function automatic logic [15:0] pick_word();
    unique case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: random stall before each result beat
  initial begin
    m_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      rx_stall = rx_steady ? 0 : $urandom_range(0, MaxGap);
      if (rx_stall != 0) begin
        m_tready <= 1'b0;
        repeat (rx_stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d samples outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme values with good CRCs, start mark at position 0
    push_frame(16'h8000, 16'h7FFF, 16'hFFFF, 3'b000, 1'b1);
    // Partial frame, then a start mark mid-frame drops it; two groups fail
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_frame(16'h0000, 16'hFFFF, 16'h0001, 3'b110, 1'b1);
    wait_drained();

    // Random: mostly well-formed replies, some cut short, some noise
    while (bytes_sent < ByteBudget) begin
      if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        push_frame(pick_word(), pick_word(), pick_word(),
                   {$urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0},
                   $urandom_range(0, 3) != 0);
      end else if (kind < 17) begin
        n_bytes = $urandom_range(1, 8);
        for (int i = 0; i < n_bytes; i++) begin
          push_byte(8'($urandom), (i == 0) && $urandom_range(0, 1));
        end
      end else begin
        n_bytes = $urandom_range(1, 4);
        for (int i = 0; i < n_bytes; i++) begin
          push_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Drove %0d reply bytes with gaps, start marks, cut frames and CRC faults.",
             bytes_sent);
    $display("Compared %0d decoded samples: %0d passed CRC, %0d rejected.",
             compared, good, compared - good);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
